@@ rtl/shifted_hamming_prealign_filter_macros.svh @@
// Assertion helpers for the prealignment filter. Both expect clk and arst_n in scope.
`ifndef SHIFTED_HAMMING_PREALIGN_FILTER_MACROS_SVH
`define SHIFTED_HAMMING_PREALIGN_FILTER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SHP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/shp_pkg.sv @@
package shp_pkg;

	localparam int MAX_LEN   = 128;
	localparam int MAX_SHIFT = 10;

	localparam int BASE_W  = 8;
	localparam int OUT_W   = 8;
	localparam int CFG_W   = 4;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam int SH_W    = $clog2(MAX_SHIFT + 2);

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

	// Per-cycle command broadcast to every cell of the row.
	typedef struct packed {
		logic cp_up;    // shifted read := own read (shift 0)
		logic cp_dn;    // shifted read := left neighbor's read (shift -1)
		logic shl;      // shifted read moves one cell toward cell 0
		logic shr;      // shifted read moves one cell away from cell 0
		logic mask_en;  // capture the mismatch bit
		logic amend;    // amend captured mask and fold into the accumulator
		logic drain;    // accumulator bits move toward cell 0 for counting
	} cell_ctl_t;

	function automatic logic [SH_W-1:0] sat_shift(input logic [CFG_W-1:0] v);
		if (int'(v) > MAX_SHIFT) begin
			return SH_W'(MAX_SHIFT);
		end
		return SH_W'(v);
	endfunction

endpackage

@@ rtl/shifted_hamming_prealign_filter.sv @@
// Shifted Hamming distance prealignment filter. Read and reference bases stream in one
// pair per beat into a row of cells, one cell per position, at one beat per cycle while
// the block is loading. The beat with tlast starts the filter: every shift from -s to +s
// (s is max_shift, capped at the design's maximum) is compared in turn, as the shifted
// read copy moves one cell along the row; an amended mask is folded into each cell's
// accumulator in the cycle after it is captured. The AND result is then counted one bit
// per cycle as it drains out through cell 0, and the count is registered for output once
// the output register is free; no input is taken from the tlast beat until then.
// Pairs beyond the row length are dropped and the result's tuser flag is set. max_shift
// may be written only while the block is idle.
`include "shifted_hamming_prealign_filter_macros.svh"

module shifted_hamming_prealign_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [shp_pkg::CFG_W-1:0]     cfg_wdata,   // max_shift
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [2*shp_pkg::BASE_W-1:0]  s_tdata,     // read_base, ref_base
	input  logic                          s_tlast,     // last
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [shp_pkg::OUT_W-1:0]     m_tdata,     // error_count
	output logic                          m_tuser      // overflowed
);

	localparam int N = shp_pkg::MAX_LEN;
	localparam int W = shp_pkg::BASE_W;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CP_UP,
		ST_UP,
		ST_CP_DN,
		ST_DN,
		ST_TAIL,
		ST_COUNT,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [shp_pkg::CFG_W-1:0]       max_shift_q;
	logic [shp_pkg::CNT_W-1:0]       cnt_q;
	logic                            ovf_q;
	logic [shp_pkg::SH_W-1:0]        shift_q;
	logic [shp_pkg::SH_W-1:0]        run_q;
	logic                            mv_s1;
	logic [shp_pkg::CNT_W-1:0]       bc_q;
	logic [shp_pkg::CNT_W-1:0]       pop_q;
	logic                            out_vld_q;
	logic [shp_pkg::OUT_W-1:0]       err_q;
	logic                            ovf_out_q;

	logic                            s_fire;
	logic                            full;
	logic                            emit_fire;
	shp_pkg::cell_ctl_t              ctl;

	logic [N-1:0]                    we;
	logic [N-1:0]                    in_rng;
	logic [N-1:0]                    amd_ok;
	logic [W-1:0]                    rd_c  [N];
	logic [W-1:0]                    sh_c  [N];
	logic [W-1:0]                    rd_ext [N+1];
	logic [W-1:0]                    sh_ext [N+2];
	logic [N+1:0]                    sv_ext;
	logic [N:0]                      rng_ext;
	logic [N+3:0]                    m_ext;
	logic [N:0]                      acc_ext;

	assign s_tready  = (state_q == ST_LOAD);
	assign s_fire    = s_tvalid && s_tready;
	assign full      = (cnt_q == shp_pkg::CNT_W'(N));
	assign emit_fire = (state_q == ST_EMIT) && (!out_vld_q || m_tready);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = err_q;
	assign m_tuser  = ovf_out_q;

	always_comb begin
		ctl         = '0;
		ctl.cp_up   = (state_q == ST_CP_UP);
		ctl.cp_dn   = (state_q == ST_CP_DN);
		ctl.shl     = (state_q == ST_UP);
		ctl.shr     = (state_q == ST_DN);
		ctl.mask_en = (state_q == ST_UP) || (state_q == ST_DN);
		ctl.amend   = mv_s1;
		ctl.drain   = (state_q == ST_COUNT) && (bc_q != '0);
	end

	// Boundaries of the row: nothing valid shifts in, and positions left of cell 0
	// read as mismatches so they never look like part of a zero run.
	assign rd_ext[0]     = '0;
	assign sh_ext[0]     = '0;
	assign sh_ext[N+1]   = '0;
	assign sv_ext[0]     = 1'b0;
	assign sv_ext[N+1]   = 1'b0;
	assign rng_ext[0]    = 1'b0;
	assign m_ext[1:0]    = 2'b11;
	assign m_ext[N+3:N+2] = 2'b00;
	assign acc_ext[N]    = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign we[i]        = s_fire && !full && (cnt_q[shp_pkg::IDX_W-1:0] == shp_pkg::IDX_W'(i));
		assign in_rng[i]    = (shp_pkg::CNT_W'(i) < cnt_q);
		assign amd_ok[i]    = ((shp_pkg::CNT_W+1)'(i + 2) < {1'b0, cnt_q});
		assign rd_ext[i+1]  = rd_c[i];
		assign sh_ext[i+1]  = sh_c[i];
		assign rng_ext[i+1] = in_rng[i];

		shp_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.we       (we[i]),
			.read_in  (s_tdata[W-1:0]),
			.ref_in   (s_tdata[2*W-1:W]),
			.in_rng   (in_rng[i]),
			.in_rng_l (rng_ext[i]),
			.amd_ok   (amd_ok[i]),
			.rd_l     (rd_ext[i]),
			.sh_l     (sh_ext[i]),
			.sv_l     (sv_ext[i]),
			.sh_r     (sh_ext[i+2]),
			.sv_r     (sv_ext[i+2]),
			.m_l1     (m_ext[i+1]),
			.m_l2     (m_ext[i]),
			.m_r1     (m_ext[i+3]),
			.m_r2     (m_ext[i+4]),
			.acc_r    (acc_ext[i+1]),
			.rd       (rd_c[i]),
			.sh       (sh_c[i]),
			.sv       (sv_ext[i+1]),
			.m        (m_ext[i+2]),
			.acc      (acc_ext[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			max_shift_q <= shp_pkg::CFG_RESET;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			shift_q     <= '0;
			run_q       <= '0;
			mv_s1       <= 1'b0;
			bc_q        <= '0;
			pop_q       <= '0;
			out_vld_q   <= 1'b0;
			err_q       <= '0;
			ovf_out_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_shift_q <= cfg_wdata;
			end
			mv_s1 <= ctl.mask_en;
			if (emit_fire) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (s_fire) begin
						if (!full) begin
							cnt_q <= cnt_q + shp_pkg::CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							shift_q <= shp_pkg::sat_shift(max_shift_q);
							state_q <= ST_CP_UP;
						end
					end
				end
				ST_CP_UP: begin
					run_q   <= shift_q;
					state_q <= ST_UP;
				end
				ST_UP: begin
					if (run_q == '0) begin
						if (shift_q == '0) begin
							state_q <= ST_TAIL;
						end else begin
							run_q   <= shift_q - shp_pkg::SH_W'(1);
							state_q <= ST_CP_DN;
						end
					end else begin
						run_q <= run_q - shp_pkg::SH_W'(1);
					end
				end
				ST_CP_DN: begin
					state_q <= ST_DN;
				end
				ST_DN: begin
					if (run_q == '0) begin
						state_q <= ST_TAIL;
					end else begin
						run_q <= run_q - shp_pkg::SH_W'(1);
					end
				end
				ST_TAIL: begin
					bc_q    <= cnt_q;
					pop_q   <= '0;
					state_q <= ST_COUNT;
				end
				ST_COUNT: begin
					if (bc_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						pop_q <= pop_q + shp_pkg::CNT_W'(acc_ext[0]);
						bc_q  <= bc_q - shp_pkg::CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						err_q     <= shp_pkg::OUT_W'(pop_q);
						ovf_out_q <= ovf_q;
						cnt_q     <= '0;
						ovf_q     <= 1'b0;
						state_q   <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	`SHP_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= shp_pkg::CNT_W'(N), "stored pair count beyond row length")
	`SHP_ASSERT_NEXT(a_last_busy, s_fire && s_tlast, !s_tready, "input taken right after the last beat")
	`SHP_ASSERT_NEXT(a_emit_clear, emit_fire, (cnt_q == '0) && !ovf_q && m_tvalid, "sequence state not cleared on result")
	`SHP_ASSERT_SAME(a_pop_bound, state_q == ST_COUNT, pop_q <= cnt_q, "count exceeds stored pairs")

endmodule

@@ rtl/shp_cell.sv @@
module shp_cell (
	input  logic                          clk,
	input  shp_pkg::cell_ctl_t            ctl,
	input  logic                          we,
	input  logic [shp_pkg::BASE_W-1:0]    read_in,
	input  logic [shp_pkg::BASE_W-1:0]    ref_in,
	input  logic                          in_rng,
	input  logic                          in_rng_l,
	input  logic                          amd_ok,
	input  logic [shp_pkg::BASE_W-1:0]    rd_l,
	input  logic [shp_pkg::BASE_W-1:0]    sh_l,
	input  logic                          sv_l,
	input  logic [shp_pkg::BASE_W-1:0]    sh_r,
	input  logic                          sv_r,
	input  logic                          m_l1,
	input  logic                          m_l2,
	input  logic                          m_r1,
	input  logic                          m_r2,
	input  logic                          acc_r,
	output logic [shp_pkg::BASE_W-1:0]    rd,
	output logic [shp_pkg::BASE_W-1:0]    sh,
	output logic                          sv,
	output logic                          m,
	output logic                          acc
);

	logic [shp_pkg::BASE_W-1:0] rd_q;
	logic [shp_pkg::BASE_W-1:0] rf_q;
	logic [shp_pkg::BASE_W-1:0] sh_q;
	logic                       sv_q;
	logic                       m_s1;
	logic                       acc_q;
	logic                       mask_d;
	logic                       am_d;

	assign mask_d = !sv_q || (sh_q != rf_q);

	// A zero in a short run (one or two zeros before a one) is filled, unless
	// three zeros in a row already end here, which marks the run as long.
	assign am_d = m_s1 || (amd_ok && ((m_r1 && !(!m_l1 && !m_l2)) || (!m_r1 && m_r2 && m_l1)));

	always_ff @(posedge clk) begin
		if (we) begin
			rd_q <= read_in;
			rf_q <= ref_in;
		end
		if (ctl.cp_up) begin
			sh_q <= rd_q;
			sv_q <= in_rng;
		end else if (ctl.cp_dn) begin
			sh_q <= rd_l;
			sv_q <= in_rng_l;
		end else if (ctl.shl) begin
			sh_q <= sh_r;
			sv_q <= sv_r;
		end else if (ctl.shr) begin
			sh_q <= sh_l;
			sv_q <= sv_l;
		end
		if (ctl.mask_en) begin
			m_s1 <= mask_d;
		end
		if (ctl.cp_up) begin
			acc_q <= in_rng;
		end else if (ctl.amend) begin
			acc_q <= acc_q && am_d;
		end else if (ctl.drain) begin
			acc_q <= acc_r;
		end
	end

	assign rd  = rd_q;
	assign sh  = sh_q;
	assign sv  = sv_q;
	assign m   = m_s1;
	assign acc = acc_q;

endmodule

@@ bench/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 2 * shp_pkg::MAX_SHIFT + shp_pkg::MAX_LEN + 16;
	localparam int STALL_LIMIT   = 4000;
	localparam int LONG_HOLD     = 600;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		logic [shp_pkg::BASE_W-1:0] read_base;
		logic [shp_pkg::BASE_W-1:0] ref_base;
		logic                       last;
	} base_pair_t;

	typedef struct packed {
		logic [shp_pkg::OUT_W-1:0] error_count;
		logic                      overflowed;
	} filter_result_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [shp_pkg::CFG_W-1:0]      cfg_wdata = '0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [2*shp_pkg::BASE_W-1:0]   s_tdata   = '0;   // read_base, ref_base
	logic                           s_tlast   = 1'b0; // last
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [shp_pkg::OUT_W-1:0]      m_tdata;          // error_count
	logic                           m_tuser;          // overflowed

	base_pair_t     pair_q[$];
	filter_result_t expected_scores[$];

	// Mirror of the block's pair store and threshold register.
	logic [shp_pkg::BASE_W-1:0] read_mem [shp_pkg::MAX_LEN];
	logic [shp_pkg::BASE_W-1:0] ref_mem  [shp_pkg::MAX_LEN];
	int                         stored_pairs  = 0;
	bit                         pairs_dropped = 1'b0;
	logic [shp_pkg::CFG_W-1:0]  shift_setting = shp_pkg::CFG_RESET;

	int idle_odds     = 0;
	int hold_requests = 0;
	int holds_served  = 0;
	int tx_gap        = 0;
	int rx_gap        = 0;
	bit pair_taken    = 1'b0;
	int failures      = 0;

	shifted_hamming_prealign_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Popcount of the ANDed amended masks over the n stored pairs.
	function automatic logic [shp_pkg::OUT_W-1:0] shd_error_count(int n);
		bit acc [shp_pkg::MAX_LEN];
		bit msk [shp_pkg::MAX_LEN];
		bit long_run;
		int s;
		int j;
		int total;
		s = (int'(shift_setting) > shp_pkg::MAX_SHIFT) ? shp_pkg::MAX_SHIFT
			: int'(shift_setting);
		total = 0;
		for (int i = 0; i < n; i++) begin
			acc[i] = 1'b1;
		end
		for (int v = -s; v <= s; v++) begin
			// Positions shifted in from outside the read always count as mismatches.
			for (int i = 0; i < n; i++) begin
				j = i + v;
				msk[i] = (j < 0 || j >= n) ? 1'b1 : (read_mem[j] != ref_mem[i]);
			end
			// A zero is kept only if it starts a run of at least three zeros, or if
			// it sits in such a run already. The last two positions stay as they are.
			long_run = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (msk[i]) begin
					long_run = 1'b0;
				end else if (!long_run && i + 2 < n) begin
					if (msk[i+1] || msk[i+2]) begin
						msk[i] = 1'b1;
					end else begin
						long_run = 1'b1;
					end
				end
			end
			for (int i = 0; i < n; i++) begin
				acc[i] = acc[i] & msk[i];
			end
		end
		for (int i = 0; i < n; i++) begin
			total += acc[i];
		end
		return shp_pkg::OUT_W'(total);
	endfunction

	function automatic void absorb_pair(logic [shp_pkg::BASE_W-1:0] rd,
			logic [shp_pkg::BASE_W-1:0] rf, logic lst);
		filter_result_t res;
		if (stored_pairs < shp_pkg::MAX_LEN) begin
			read_mem[stored_pairs] = rd;
			ref_mem[stored_pairs]  = rf;
			stored_pairs++;
		end else begin
			pairs_dropped = 1'b1;
		end
		if (lst) begin
			res.error_count = shd_error_count(stored_pairs);
			res.overflowed  = pairs_dropped;
			expected_scores = {expected_scores, res};
			stored_pairs  = 0;
			pairs_dropped = 1'b0;
		end
	endfunction

	// Input and output beats are sampled at the rising edge.
	always @(posedge clk) begin
		filter_result_t want;
		pair_taken = s_tvalid && s_tready;
		if (pair_taken) begin
			absorb_pair(s_tdata[shp_pkg::BASE_W-1:0],
				s_tdata[2*shp_pkg::BASE_W-1:shp_pkg::BASE_W], s_tlast);
		end
		if (m_tvalid === 1'b1 && m_tready) begin
			if (expected_scores.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX) begin
					$display("%0t: unexpected result beat: error_count=%0d overflowed=%0b",
						$realtime, m_tdata, m_tuser);
				end
			end else begin
				want = expected_scores.pop_front();
				if (m_tdata !== want.error_count || m_tuser !== want.overflowed) begin
					failures++;
					if (failures <= REPORT_MAX) begin
						$display("%0t: mismatch: error_count exp %0d got %0d, %s",
							$realtime, want.error_count, m_tdata,
							$sformatf("overflowed exp %0b got %0b",
								want.overflowed, m_tuser));
					end
				end
			end
		end
	end

	// Sender: a beat on the bus stays until it is taken; gaps start only between beats.
	always @(negedge clk) begin
		base_pair_t nxt;
		if (!s_tvalid || pair_taken) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (pair_q.size() > 0 && idle_odds > 0
					&& $urandom_range(0, 99) < idle_odds) begin
				tx_gap = $urandom_range(0, 16);
				s_tvalid <= 1'b0;
			end else if (pair_q.size() > 0) begin
				nxt = pair_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {nxt.ref_base, nxt.read_base};
				s_tlast  <= nxt.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			rx_gap = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
			rx_gap = $urandom_range(0, 16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [shp_pkg::BASE_W-1:0] nucleotide(int k);
		case (k % 4)
			0: return "A";
			1: return "C";
			2: return "G";
			default: return "T";
		endcase
	endfunction

	task automatic push_pair(logic [shp_pkg::BASE_W-1:0] rd, logic [shp_pkg::BASE_W-1:0] rf,
			logic lst);
		base_pair_t p;
		p.read_base = rd;
		p.ref_base  = rf;
		p.last      = lst;
		pair_q = {pair_q, p};
	endtask

	// A read and a reference that mostly agree, with an indel-like shift and a few
	// substitutions; now and then both are arbitrary bytes.
	task automatic queue_random_seq(int len);
		logic [shp_pkg::BASE_W-1:0] rd [$];
		logic [shp_pkg::BASE_W-1:0] rf [$];
		logic [shp_pkg::BASE_W-1:0] b;
		bit noisy;
		int d;
		int p;
		int edits;
		noisy = ($urandom_range(0, 7) == 0);
		for (int i = 0; i < len; i++) begin
			b = noisy ? shp_pkg::BASE_W'($urandom) : nucleotide($urandom_range(0, 3));
			rd = {rd, b};
		end
		rf = rd;
		if (noisy) begin
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 3) != 0) begin
					rf[i] = shp_pkg::BASE_W'($urandom);
				end
			end
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				d = $urandom_range(0, 6) - 3;
				p = $urandom_range(0, len - 1);
				for (int i = p; i < len; i++) begin
					rf[i] = (i + d >= 0 && i + d < len) ? rd[i+d]
						: nucleotide($urandom_range(0, 3));
				end
			end
			edits = $urandom_range(0, 3);
			for (int e = 0; e < edits; e++) begin
				rf[$urandom_range(0, len - 1)] = nucleotide($urandom_range(0, 3));
			end
		end
		for (int i = 0; i < len; i++) begin
			push_pair(rd[i], rf[i], i == len - 1);
		end
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			return $urandom_range(shp_pkg::MAX_LEN + 1, shp_pkg::MAX_LEN + 12);
		end
		if (r < 12) begin
			return $urandom_range(25, shp_pkg::MAX_LEN);
		end
		return $urandom_range(1, 24);
	endfunction

	task automatic run_random(int n_items);
		int queued;
		int len;
		queued = 0;
		while (queued < n_items) begin
			len = pick_len();
			queue_random_seq(len);
			queued += len;
		end
	endtask

	// Returns once every pair is taken and every result has come back, then lets the
	// block settle so that the threshold may be rewritten.
	task automatic wait_idle();
		do begin
			@(posedge clk);
		end while (!(pair_q.size() == 0 && !s_tvalid && expected_scores.size() == 0));
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_shift(logic [shp_pkg::CFG_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		shift_setting = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed sequences at the reset threshold.
		idle_odds = 15;
		push_pair(8'h00, 8'h00, 1'b1);
		push_pair(8'hFF, 8'hFF, 1'b0);
		push_pair(8'hFF, 8'h00, 1'b1);
		push_pair(8'h00, 8'hFF, 1'b0);
		push_pair(8'hFF, 8'h00, 1'b0);
		push_pair("A", "A", 1'b1);
		// Reference is the read moved by one position.
		for (int i = 0; i < 8; i++) begin
			push_pair(nucleotide(i), nucleotide(i + 1), i == 7);
		end
		// Long run of matches with a single substitution in the middle.
		for (int i = 0; i < 10; i++) begin
			push_pair(nucleotide(i), (i == 5) ? 8'h80 : nucleotide(i), i == 9);
		end
		wait_idle();

		// Full and overflowing stores at the largest threshold, with the
		// receiver holding off long enough that the block backs up.
		write_shift(shp_pkg::CFG_W'(shp_pkg::MAX_SHIFT));
		hold_requests++;
		queue_random_seq(shp_pkg::MAX_LEN);
		queue_random_seq(shp_pkg::MAX_LEN + 1);
		queue_random_seq(shp_pkg::MAX_LEN + 12);
		wait_idle();

		write_shift('0);
		idle_odds = 25;
		run_random(300);
		wait_idle();

		// Above the design maximum; the block saturates it.
		write_shift('1);
		idle_odds = 10;
		run_random(300);
		wait_idle();

		write_shift(shp_pkg::CFG_W'(1));
		idle_odds = 0;
		run_random(250);
		wait_idle();

		write_shift(shp_pkg::CFG_W'(shp_pkg::MAX_SHIFT + 1));
		idle_odds = 35;
		run_random(250);
		wait_idle();

		write_shift(shp_pkg::CFG_W'($urandom_range(2, 9)));
		idle_odds = 0;
		run_random(200);
		wait_idle();

		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
